// File: rtl/pccm_pkg.sv
`default_nettype none

package pccm_pkg;

   localparam int NUM_CH    = 3;
   localparam int PIX_W     = 8;
   localparam int WGT_W     = 9;
   localparam int FRAC_W    = 16;
   localparam int RECIP_W   = 25;
   localparam int NUM_W     = PIX_W + FRAC_W;
   localparam int TERM_W    = NUM_W + 1;
   localparam int WPROD_W   = TERM_W + WGT_W + 1;
   localparam int SUM_W     = WPROD_W + 2;
   localparam int SCALE_W   = SUM_W - 1 + PIX_W;
   localparam int LATENCY   = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 9;

   localparam logic signed [TERM_W-1:0] TERM_ONE = TERM_W'(1 << FRAC_W);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TARGET_BLUE  = 3'd0,
      REG_TARGET_GREEN = 3'd1,
      REG_TARGET_RED   = 3'd2,
      REG_WEIGHT_BLUE  = 3'd3,
      REG_WEIGHT_GREEN = 3'd4,
      REG_WEIGHT_RED   = 3'd5,
      REG_MIN_RATING   = 3'd6
   } csr_index_type;

   typedef logic [PIX_W-1:0]           pix_type;
   typedef logic [WGT_W-1:0]           wgt_type;
   typedef logic signed [TERM_W-1:0]   term_type;

endpackage

`default_nettype wire

// File: rtl/pixel_color_closeness_mask.sv
`default_nettype none

// Pixel color closeness mask.
// Rates one BGR pixel against a programmed reference color. Each channel
// gives a closeness term 1 - |p - t| / t, the terms are weighted and summed,
// and a sum below min_rating gives 0; otherwise the output is
// floor(sum * 255), clipped at 255. A zero reference channel accepts only a
// zero pixel channel.
// Request channel: a pixel is taken at each rising edge with start high and
// busy low. busy is always low, so a pixel can be issued every cycle.
// Response channel: rsp_valid pulses for one cycle with rsp_rating. The
// receiver cannot stall; results are never held back, so throughput is
// one pixel per clock.
// The divide |p - t| / t is a reciprocal table lookup, a multiply and a
// single remainder correction, spread over the first four stages; the
// weighting multiply, the sum and the threshold/scale take the rest.
// CSR channel: csr_ready is always high; write only while no request is in
// flight. Index 7 is ignored.
// Reset (synchronous, active high) flushes the pipeline and loads the
// default reference color, weights and threshold.

module pixel_color_closeness_mask (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           start,
   output logic                          busy,
   input  wire  [pccm_pkg::PIX_W-1:0]    req_pixel_blue,
   input  wire  [pccm_pkg::PIX_W-1:0]    req_pixel_green,
   input  wire  [pccm_pkg::PIX_W-1:0]    req_pixel_red,
   output logic                          rsp_valid,
   output logic [pccm_pkg::PIX_W-1:0]    rsp_rating,
   input  wire                           csr_valid,
   output logic                          csr_ready,
   input  wire  [pccm_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire  [pccm_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import pccm_pkg::*;

   // configuration
   pix_type target_ff [NUM_CH];
   wgt_type weight_ff [NUM_CH];
   wgt_type min_rating_ff;

   logic [LATENCY-1:0] valid_ff;
   logic [LATENCY-1:0] valid_in;
   logic               accept;

   // reciprocal table floor(2^24 / t)
   logic [RECIP_W-1:0] recip_table [256];

   // stage 1
   pix_type            diff1_ff  [NUM_CH];
   logic [RECIP_W-1:0] recip1_ff [NUM_CH];
   logic [NUM_CH-1:0]  zero1_ff;
   logic               rej1_ff;
   // stage 2
   logic [PIX_W+RECIP_W-1:0] prod2_ff [NUM_CH];
   pix_type            diff2_ff  [NUM_CH];
   logic [NUM_CH-1:0]  zero2_ff;
   logic               rej2_ff;
   // stage 3
   logic [NUM_W-1:0]   qest3_ff [NUM_CH];
   logic [NUM_W-1:0]   qt3_ff   [NUM_CH];
   logic [NUM_W-1:0]   num3_ff  [NUM_CH];
   logic [NUM_CH-1:0]  zero3_ff;
   logic               rej3_ff;
   // stage 4
   term_type           term4_ff [NUM_CH];
   logic               rej4_ff;
   // stage 5
   logic signed [WPROD_W-1:0] wprod5_ff [NUM_CH];
   logic               rej5_ff;
   // stage 6
   logic signed [SUM_W-1:0] sum6_ff;
   logic               rej6_ff;
   // stage 7
   logic [SCALE_W-1-24:0] scaled7_ff;
   logic               pass7_ff;
   // stage 8
   pix_type            rating8_ff;

   logic [NUM_W-1:0]   rem4     [NUM_CH];
   logic [NUM_W-1:0]   qfix4    [NUM_CH];
   logic [SCALE_W-1:0] scaled_full;
   logic               pass_in;
   pix_type            pix_in   [NUM_CH];
   logic [NUM_CH-1:0]  rej_ch;

   assign recip_table[0] = '0;
   for (genvar g = 1; g < 256; g++) begin : g_recip
      localparam logic [RECIP_W-1:0] RecipVal = RECIP_W'((1 << 24) / g);
      assign recip_table[g] = RecipVal;
   end

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign valid_in  = {valid_ff[LATENCY-2:0], accept};
   assign rsp_valid = valid_ff[LATENCY-1];
   assign rsp_rating = rating8_ff;

   assign pix_in[0] = req_pixel_blue;
   assign pix_in[1] = req_pixel_green;
   assign pix_in[2] = req_pixel_red;

   always_comb begin
      for (int i = 0; i < NUM_CH; i++) begin
         rej_ch[i] = (target_ff[i] == '0) && (pix_in[i] != '0);
         rem4[i]   = num3_ff[i] - qt3_ff[i];
         // estimate is low by at most one
         qfix4[i]  = qest3_ff[i] + NUM_W'(rem4[i] >= NUM_W'(target_ff[i]));
      end
      pass_in     = !rej6_ff && !sum6_ff[SUM_W-1] &&
                    (sum6_ff >= $signed({(SUM_W-WGT_W-FRAC_W)'(0), min_rating_ff,
                                         FRAC_W'(0)}));
      scaled_full = {sum6_ff[SUM_W-2:0], 8'b0} - {8'b0, sum6_ff[SUM_W-2:0]};
   end

   // configuration registers and valid pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff[0]  <= 8'd36;
         target_ff[1]  <= 8'd102;
         target_ff[2]  <= 8'd4;
         weight_ff[0]  <= 9'd51;
         weight_ff[1]  <= 9'd154;
         weight_ff[2]  <= 9'd51;
         min_rating_ff <= 9'd154;
         valid_ff      <= '0;
      end else begin
         valid_ff <= valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_TARGET_BLUE:  target_ff[0]  <= csr_wdata[PIX_W-1:0];
               REG_TARGET_GREEN: target_ff[1]  <= csr_wdata[PIX_W-1:0];
               REG_TARGET_RED:   target_ff[2]  <= csr_wdata[PIX_W-1:0];
               REG_WEIGHT_BLUE:  weight_ff[0]  <= csr_wdata[WGT_W-1:0];
               REG_WEIGHT_GREEN: weight_ff[1]  <= csr_wdata[WGT_W-1:0];
               REG_WEIGHT_RED:   weight_ff[2]  <= csr_wdata[WGT_W-1:0];
               REG_MIN_RATING:   min_rating_ff <= csr_wdata[WGT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_CH; i++) begin
         diff1_ff[i]  <= (pix_in[i] > target_ff[i]) ? pix_in[i] - target_ff[i]
                                                    : target_ff[i] - pix_in[i];
         recip1_ff[i] <= recip_table[target_ff[i]];
         zero1_ff[i]  <= (target_ff[i] == '0);

         prod2_ff[i]  <= (PIX_W+RECIP_W)'(diff1_ff[i]) * (PIX_W+RECIP_W)'(recip1_ff[i]);
         diff2_ff[i]  <= diff1_ff[i];
         zero2_ff[i]  <= zero1_ff[i];

         qest3_ff[i]  <= prod2_ff[i][NUM_W+7:8];
         qt3_ff[i]    <= NUM_W'(NUM_W'(prod2_ff[i][NUM_W+7:8]) * NUM_W'(target_ff[i]));
         num3_ff[i]   <= {diff2_ff[i], FRAC_W'(0)};
         zero3_ff[i]  <= zero2_ff[i];

         term4_ff[i]  <= zero3_ff[i] ? TERM_ONE : TERM_ONE - $signed({1'b0, qfix4[i]});

         wprod5_ff[i] <= WPROD_W'(term4_ff[i]) *
                         WPROD_W'($signed({1'b0, weight_ff[i]}));
      end
      rej1_ff    <= |rej_ch;
      rej2_ff    <= rej1_ff;
      rej3_ff    <= rej2_ff;
      rej4_ff    <= rej3_ff;
      rej5_ff    <= rej4_ff;

      sum6_ff    <= SUM_W'(wprod5_ff[0]) + SUM_W'(wprod5_ff[1]) + SUM_W'(wprod5_ff[2]);
      rej6_ff    <= rej5_ff;

      scaled7_ff <= scaled_full[SCALE_W-1:24];
      pass7_ff   <= pass_in;

      if (!pass7_ff) begin
         rating8_ff <= '0;
      end else if (scaled7_ff > (SCALE_W-24)'(255)) begin
         rating8_ff <= 8'hFF;
      end else begin
         rating8_ff <= scaled7_ff[PIX_W-1:0];
      end
   end

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("response without a request eight cycles earlier");

   a_quot_est: assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] && !zero3_ff[0] |->
         rem4[0] < (NUM_W'(target_ff[0]) << 1))
      else $error("blue quotient estimate off by more than one");

   a_term_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] |-> term4_ff[1] <= TERM_ONE &&
                      term4_ff[1] >= -$signed(TERM_W'(254 << FRAC_W)))
      else $error("green closeness term out of range");

   a_reject: assert property (@(posedge clock) disable iff (reset)
      valid_ff[5] && rej6_ff |=> !pass7_ff)
      else $error("rejected pixel passed threshold");
`endif

endmodule

`default_nettype wire
